/* design/sdspi_pkg.sv */
// Package for the SD SPI host controller: payload structs, phase and
// command context enums, register indexes and protocol constants.
// No dependencies.
`default_nettype none
package sdspi_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int BC_W = $clog2(BLOCK_BYTES + 1);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_BYTE  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    P_IDLE, P_INIT_CLOCKS, P_CMD0_PRE, P_CMD_FRAME, P_CMD_POLL, P_CMD_TRAIL,
    P_CMD8_ECHO, P_CMD8_TAIL, P_V1_GAP, P_OCR, P_OCR_TAIL, P_DUMMY,
    P_RD_TOKEN, P_RD_DATA, P_RD_CRC, P_RD_TAIL,
    P_WR_PRE, P_WR_DATA, P_WR_CRC, P_WR_RESP, P_WR_BUSY
  } phase_t;

  typedef enum logic [3:0] {
    C_CMD0, C_CMD8, C_CMD55_V2, C_ACMD41_V2, C_CMD58, C_CMD55_V1,
    C_ACMD41_V1, C_CMD1, C_CMD16, C_CMD17, C_CMD24
  } ctx_t;

  localparam logic [2:0] REG_RESP_WAIT  = 3'd0;
  localparam logic [2:0] REG_IDLE_CMD   = 3'd1;
  localparam logic [2:0] REG_ACMD41_V2  = 3'd2;
  localparam logic [2:0] REG_ACMD41_V1  = 3'd3;
  localparam logic [2:0] REG_MMC_INIT   = 3'd4;
  localparam logic [2:0] REG_BLOCKLEN   = 3'd5;
  localparam logic [2:0] REG_PROTECT    = 3'd6;

  localparam logic [1:0] TYPE_MMC  = 2'd0;
  localparam logic [1:0] TYPE_SDV1 = 2'd1;
  localparam logic [1:0] TYPE_SDV2 = 2'd2;
  localparam logic [1:0] TYPE_SDHC = 2'd3;

  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] CRC_CMD0    = 8'h95;
  localparam logic [7:0] CRC_CMD8    = 8'h87;
  localparam logic [7:0] CRC_DUMMY   = 8'h01;
  localparam logic [7:0] CMD_START   = 8'h40;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] R1_ILLEGAL  = 8'h05;
  localparam logic [7:0] DRESP_MASK  = 8'h1F;
  localparam logic [7:0] DRESP_OK    = 8'h05;
  localparam logic [7:0] ST_REFUSED  = 8'hFF;
  localparam logic [15:0] CMD8_ECHO  = 16'h01AA;
  localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS    = 32'h4000_0000;
  localparam logic [31:0] ARG_BLKLEN = 32'h0000_0200;

  localparam logic [5:0] CMD0  = 6'd0;
  localparam logic [5:0] CMD1  = 6'd1;
  localparam logic [5:0] CMD8  = 6'd8;
  localparam logic [5:0] CMD16 = 6'd16;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD24 = 6'd24;
  localparam logic [5:0] CMD41 = 6'd41;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sector;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       exchange_request;
    logic       chip_select;
    logic       fast_clock;
    logic       need_write_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [7:0] status;
    logic [1:0] card_type;
  } out_item_t;

  typedef struct packed {
    logic [7:0] resp_wait;
    logic [7:0] idle_cmd;
    logic [7:0] acmd41_v2;
    logic [7:0] acmd41_v1;
    logic [7:0] mmc_init;
    logic [7:0] blocklen;
    logic       protect;
  } cfg_t;

endpackage
`default_nettype wire

/* design/sdspi_cfg_regs.sv */
// Configuration register file of the SD SPI host controller.
// Depends on sdspi_pkg.
`default_nettype none
module sdspi_cfg_regs import sdspi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output cfg_t            cfg
);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{resp_wait: 8'd10, idle_cmd: 8'd11, acmd41_v2: 8'd51, acmd41_v1: 8'd100,
               mmc_init: 8'd100, blocklen: 8'd20, protect: 1'b1};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RESP_WAIT: cfg.resp_wait <= cfg_data;
        REG_IDLE_CMD:  cfg.idle_cmd  <= cfg_data;
        REG_ACMD41_V2: cfg.acmd41_v2 <= cfg_data;
        REG_ACMD41_V1: cfg.acmd41_v1 <= cfg_data;
        REG_MMC_INIT:  cfg.mmc_init  <= cfg_data;
        REG_BLOCKLEN:  cfg.blocklen  <= cfg_data;
        REG_PROTECT:   cfg.protect   <= cfg_data[0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/sdspi_fsm.sv */
// Byte-rate control machine: one beat in, one optional result out per cycle in which step is high.
// Depends on sdspi_pkg.
`default_nettype none
module sdspi_fsm import sdspi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  in_item_t      item,
  input  cfg_t          cfg,
  output logic          has_res,
  output out_item_t     res
);
  phase_t      phase, phase_next;
  logic [2:0]  frame_index, frame_index_next;
  logic [7:0]  attempt_count, attempt_count_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [BC_W-1:0] byte_count, byte_count_next;
  logic [31:0] command_arg, command_arg_next;
  logic [15:0] echo_bytes, echo_bytes_next;
  logic [1:0]  detected_type, detected_type_next;
  logic        clock_fast, clock_fast_next;
  logic [5:0]  cmd_code, cmd_code_next;
  ctx_t        cmd_ctx, cmd_ctx_next;
  logic [7:0]  cmd_resp, cmd_resp_next;
  logic [7:0]  reset_a, reset_a_next;
  logic        cmd_keep, cmd_keep_next;
  logic        cs_on, cs_on_next;

  logic [7:0] mosi, rb, st;
  logic       req, nwb, rv, done;
  logic [7:0] r;
  logic       do_cmd_done;
  logic [7:0] att_inc;
  logic [2:0] fi_inc;
  logic [31:0] arg;
  logic [BC_W-1:0] bc_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE; frame_index <= '0; attempt_count <= '0; poll_count <= '0;
      byte_count <= '0; command_arg <= '0; echo_bytes <= '0; detected_type <= '0;
      clock_fast <= 1'b0; cmd_code <= '0; cmd_ctx <= C_CMD0; cmd_resp <= '0;
      reset_a <= '0; cmd_keep <= 1'b0; cs_on <= 1'b0;
    end else if (step) begin
      phase <= phase_next; frame_index <= frame_index_next;
      attempt_count <= attempt_count_next; poll_count <= poll_count_next;
      byte_count <= byte_count_next; command_arg <= command_arg_next;
      echo_bytes <= echo_bytes_next; detected_type <= detected_type_next;
      clock_fast <= clock_fast_next; cmd_code <= cmd_code_next; cmd_ctx <= cmd_ctx_next;
      cmd_resp <= cmd_resp_next; reset_a <= reset_a_next; cmd_keep <= cmd_keep_next;
      cs_on <= cs_on_next;
    end
  end

  always_comb begin
    phase_next = phase; frame_index_next = frame_index;
    attempt_count_next = attempt_count; poll_count_next = poll_count;
    byte_count_next = byte_count; command_arg_next = command_arg;
    echo_bytes_next = echo_bytes; detected_type_next = detected_type;
    clock_fast_next = clock_fast; cmd_code_next = cmd_code; cmd_ctx_next = cmd_ctx;
    cmd_resp_next = cmd_resp; reset_a_next = reset_a; cmd_keep_next = cmd_keep;
    cs_on_next = cs_on;
    mosi = BYTE_IDLE; req = 1'b0; nwb = 1'b0; rv = 1'b0; rb = 8'h00;
    done = 1'b0; st = 8'h00; has_res = 1'b0;
    r = 8'h00; do_cmd_done = 1'b0;
    att_inc = attempt_count + 8'd1;
    fi_inc = frame_index + 3'd1;
    bc_inc = byte_count + BC_W'(1);
    arg = (detected_type == TYPE_SDHC) ? item.sector : {item.sector[22:0], 9'd0};

    if (item.op != OP_BYTE) begin
      if (phase == P_IDLE) begin
        has_res = 1'b1;
        priority if (item.op == OP_INIT) begin
          clock_fast_next = 1'b0;
          cs_on_next = 1'b0; byte_count_next = '0; phase_next = P_INIT_CLOCKS;
          req = 1'b1; mosi = BYTE_IDLE;
        end else if (item.op == OP_READ) begin
          cmd_code_next = CMD17; command_arg_next = arg; cmd_keep_next = 1'b0;
          cmd_ctx_next = C_CMD17; cs_on_next = 1'b1; frame_index_next = '0;
          phase_next = P_CMD_FRAME; req = 1'b1; mosi = CMD_START | {2'b00, CMD17};
        end else if (cfg.protect && item.sector == 32'd0) begin
          done = 1'b1; st = ST_REFUSED; phase_next = P_IDLE;
        end else begin
          cmd_code_next = CMD24; command_arg_next = arg; cmd_keep_next = 1'b0;
          cmd_ctx_next = C_CMD24; cs_on_next = 1'b1; frame_index_next = '0;
          phase_next = P_CMD_FRAME; req = 1'b1; mosi = CMD_START | {2'b00, CMD24};
        end
      end
    end else if (phase != P_IDLE) begin
      has_res = 1'b1;
      unique case (phase)
        P_INIT_CLOCKS: begin
          byte_count_next = bc_inc; req = 1'b1; mosi = BYTE_IDLE;
          if (bc_inc >= BC_W'(10)) begin
            attempt_count_next = '0; cs_on_next = 1'b1; byte_count_next = '0;
            phase_next = P_CMD0_PRE;
          end
        end
        P_CMD0_PRE: begin
          byte_count_next = bc_inc; req = 1'b1; mosi = BYTE_IDLE;
          if (bc_inc >= BC_W'(2)) begin
            cmd_code_next = CMD0; command_arg_next = '0; cmd_keep_next = 1'b0;
            cmd_ctx_next = C_CMD0; cs_on_next = 1'b1; frame_index_next = '0;
            phase_next = P_CMD_FRAME; mosi = CMD_START;
          end
        end
        P_CMD_FRAME: begin
          frame_index_next = fi_inc; req = 1'b1;
          if (fi_inc < 3'd6) begin
            unique case (fi_inc)
              3'd1: mosi = command_arg[31:24];
              3'd2: mosi = command_arg[23:16];
              3'd3: mosi = command_arg[15:8];
              3'd4: mosi = command_arg[7:0];
              default: mosi = (cmd_code == CMD0) ? CRC_CMD0 :
                              (cmd_code == CMD8) ? CRC_CMD8 : CRC_DUMMY;
            endcase
          end else begin
            poll_count_next = '0; phase_next = P_CMD_POLL; mosi = BYTE_IDLE;
          end
        end
        P_CMD_POLL: begin
          poll_count_next = poll_count + 8'd1;
          if (item.miso_byte == BYTE_IDLE && (poll_count + 8'd1) < cfg.resp_wait) begin
            req = 1'b1; mosi = BYTE_IDLE;
          end else if (cmd_keep) begin
            do_cmd_done = 1'b1; r = item.miso_byte;
          end else begin
            cmd_resp_next = item.miso_byte; cs_on_next = 1'b0; phase_next = P_CMD_TRAIL;
            req = 1'b1; mosi = BYTE_IDLE;
          end
        end
        P_CMD_TRAIL: begin
          do_cmd_done = 1'b1; r = cmd_resp;
        end
        P_CMD8_ECHO: begin
          echo_bytes_next = {echo_bytes[7:0], item.miso_byte};
          byte_count_next = bc_inc; req = 1'b1; mosi = BYTE_IDLE;
          if (bc_inc >= BC_W'(4)) begin
            cs_on_next = 1'b0; phase_next = P_CMD8_TAIL;
          end
        end
        P_CMD8_TAIL: begin
          req = 1'b1;
          if (echo_bytes == CMD8_ECHO) begin
            attempt_count_next = '0; cmd_code_next = CMD55; command_arg_next = '0;
            cmd_keep_next = 1'b0; cmd_ctx_next = C_CMD55_V2; cs_on_next = 1'b1;
            frame_index_next = '0; phase_next = P_CMD_FRAME;
            mosi = CMD_START | {2'b00, CMD55};
          end else begin
            phase_next = P_DUMMY; mosi = BYTE_IDLE;
          end
        end
        P_V1_GAP: begin
          attempt_count_next = '0; cmd_code_next = CMD55; command_arg_next = '0;
          cmd_keep_next = 1'b0; cmd_ctx_next = C_CMD55_V1; cs_on_next = 1'b1;
          frame_index_next = '0; phase_next = P_CMD_FRAME; req = 1'b1;
          mosi = CMD_START | {2'b00, CMD55};
        end
        P_OCR: begin
          if (byte_count == '0) echo_bytes_next = {8'h00, item.miso_byte};
          byte_count_next = bc_inc; req = 1'b1; mosi = BYTE_IDLE;
          if (bc_inc >= BC_W'(4)) begin
            cs_on_next = 1'b0; phase_next = P_OCR_TAIL;
          end
        end
        P_OCR_TAIL: begin
          detected_type_next = echo_bytes[6] ? TYPE_SDHC : TYPE_SDV2;
          phase_next = P_DUMMY; req = 1'b1; mosi = BYTE_IDLE;
        end
        P_DUMMY: begin
          if (detected_type != TYPE_SDHC) begin
            attempt_count_next = 8'd1; cmd_code_next = CMD16; command_arg_next = ARG_BLKLEN;
            cmd_keep_next = 1'b0; cmd_ctx_next = C_CMD16; cs_on_next = 1'b1;
            frame_index_next = '0; phase_next = P_CMD_FRAME; req = 1'b1;
            mosi = CMD_START | {2'b00, CMD16};
          end else if (reset_a == 8'd0) begin
            clock_fast_next = 1'b1; done = 1'b1; phase_next = P_IDLE;
          end else begin
            cs_on_next = 1'b0; byte_count_next = '0; phase_next = P_INIT_CLOCKS;
            req = 1'b1; mosi = BYTE_IDLE;
          end
        end
        P_RD_TOKEN: begin
          if (item.miso_byte == TOKEN_START) begin
            byte_count_next = '0; phase_next = P_RD_DATA;
          end
          req = 1'b1; mosi = BYTE_IDLE;
        end
        P_RD_DATA: begin
          rv = 1'b1; rb = item.miso_byte; byte_count_next = bc_inc;
          if (bc_inc >= BC_W'(BLOCK_BYTES)) begin
            byte_count_next = '0; phase_next = P_RD_CRC;
          end
          req = 1'b1; mosi = BYTE_IDLE;
        end
        P_RD_CRC: begin
          byte_count_next = bc_inc;
          if (bc_inc >= BC_W'(2)) begin
            cs_on_next = 1'b0; phase_next = P_RD_TAIL;
          end
          req = 1'b1; mosi = BYTE_IDLE;
        end
        P_RD_TAIL: begin
          done = 1'b1; phase_next = P_IDLE;
        end
        P_WR_PRE: begin
          byte_count_next = bc_inc; req = 1'b1; mosi = BYTE_IDLE;
          if (bc_inc >= BC_W'(3)) begin
            byte_count_next = '0; phase_next = P_WR_DATA; mosi = TOKEN_START; nwb = 1'b1;
          end
        end
        P_WR_DATA: begin
          req = 1'b1;
          if (byte_count < BC_W'(BLOCK_BYTES)) begin
            byte_count_next = bc_inc; mosi = item.write_byte;
            nwb = (bc_inc < BC_W'(BLOCK_BYTES));
          end else begin
            byte_count_next = BC_W'(1); phase_next = P_WR_CRC; mosi = BYTE_IDLE;
          end
        end
        P_WR_CRC: begin
          if (byte_count < BC_W'(2)) byte_count_next = bc_inc;
          else phase_next = P_WR_RESP;
          req = 1'b1; mosi = BYTE_IDLE;
        end
        P_WR_RESP: begin
          if ((item.miso_byte & DRESP_MASK) != DRESP_OK) begin
            cs_on_next = 1'b0; done = 1'b1; st = item.miso_byte; phase_next = P_IDLE;
          end else begin
            phase_next = P_WR_BUSY; req = 1'b1; mosi = BYTE_IDLE;
          end
        end
        P_WR_BUSY: begin
          if (item.miso_byte == 8'd0) begin
            req = 1'b1; mosi = BYTE_IDLE;
          end else begin
            cs_on_next = 1'b0; done = 1'b1; phase_next = P_IDLE;
          end
        end
        default: phase_next = P_IDLE;
      endcase

      if (do_cmd_done) begin
        // command completion: r is the R1 byte of the finished command
        unique case (cmd_ctx)
          C_CMD0: begin
            reset_a_next = r; attempt_count_next = att_inc; req = 1'b1;
            if (att_inc >= cfg.idle_cmd) begin
              cs_on_next = 1'b0; byte_count_next = '0; phase_next = P_INIT_CLOCKS;
              mosi = BYTE_IDLE;
            end else if (r != R1_IDLE) begin
              cs_on_next = 1'b1; byte_count_next = '0; phase_next = P_CMD0_PRE;
              mosi = BYTE_IDLE;
            end else begin
              cmd_code_next = CMD8; command_arg_next = ARG_CMD8; cmd_keep_next = 1'b1;
              cmd_ctx_next = C_CMD8; cs_on_next = 1'b1; frame_index_next = '0;
              phase_next = P_CMD_FRAME; mosi = CMD_START | {2'b00, CMD8};
            end
          end
          C_CMD8: begin
            req = 1'b1; mosi = BYTE_IDLE;
            if (r == R1_IDLE) begin
              byte_count_next = '0; echo_bytes_next = '0; phase_next = P_CMD8_ECHO;
            end else if (r == R1_ILLEGAL) phase_next = P_V1_GAP;
            else phase_next = P_DUMMY;
          end
          C_CMD55_V2, C_CMD55_V1: begin
            reset_a_next = r;
            if (r != R1_IDLE) begin
              if (r == 8'd0) begin
                clock_fast_next = 1'b1; done = 1'b1; phase_next = P_IDLE;
              end else begin
                cs_on_next = 1'b0; byte_count_next = '0; phase_next = P_INIT_CLOCKS;
                req = 1'b1; mosi = BYTE_IDLE;
              end
            end else begin
              cmd_code_next = CMD41;
              command_arg_next = (cmd_ctx == C_CMD55_V2) ? ARG_HCS : 32'd0;
              cmd_keep_next = 1'b0;
              cmd_ctx_next = (cmd_ctx == C_CMD55_V2) ? C_ACMD41_V2 : C_ACMD41_V1;
              cs_on_next = 1'b1; frame_index_next = '0; phase_next = P_CMD_FRAME;
              req = 1'b1; mosi = CMD_START | {2'b00, CMD41};
            end
          end
          C_ACMD41_V2: begin
            reset_a_next = r; attempt_count_next = att_inc;
            if (att_inc >= cfg.acmd41_v2) begin
              if (r == 8'd0) begin
                clock_fast_next = 1'b1; done = 1'b1; phase_next = P_IDLE;
              end else begin
                cs_on_next = 1'b0; byte_count_next = '0; phase_next = P_INIT_CLOCKS;
                req = 1'b1; mosi = BYTE_IDLE;
              end
            end else begin
              cmd_code_next = (r != 8'd0) ? CMD55 : CMD58; command_arg_next = '0;
              cmd_keep_next = (r == 8'd0);
              cmd_ctx_next = (r != 8'd0) ? C_CMD55_V2 : C_CMD58;
              cs_on_next = 1'b1; frame_index_next = '0; phase_next = P_CMD_FRAME;
              req = 1'b1;
              mosi = CMD_START | {2'b00, ((r != 8'd0) ? CMD55 : CMD58)};
            end
          end
          C_CMD58: begin
            reset_a_next = r; req = 1'b1; mosi = BYTE_IDLE;
            if (r != 8'd0) begin
              cs_on_next = 1'b0; byte_count_next = '0; phase_next = P_INIT_CLOCKS;
            end else begin
              byte_count_next = '0; phase_next = P_OCR;
            end
          end
          C_ACMD41_V1: begin
            reset_a_next = r; attempt_count_next = att_inc; req = 1'b1;
            if (r != 8'd0 && att_inc < cfg.acmd41_v1) begin
              cmd_code_next = CMD55; command_arg_next = '0; cmd_keep_next = 1'b0;
              cmd_ctx_next = C_CMD55_V1; cs_on_next = 1'b1; frame_index_next = '0;
              phase_next = P_CMD_FRAME; mosi = CMD_START | {2'b00, CMD55};
            end else if (att_inc >= cfg.acmd41_v1) begin
              attempt_count_next = '0; cmd_code_next = CMD1; command_arg_next = '0;
              cmd_keep_next = 1'b0; cmd_ctx_next = C_CMD1; cs_on_next = 1'b1;
              frame_index_next = '0; phase_next = P_CMD_FRAME;
              mosi = CMD_START | {2'b00, CMD1};
            end else begin
              detected_type_next = TYPE_SDV1; phase_next = P_DUMMY; mosi = BYTE_IDLE;
            end
          end
          C_CMD1: begin
            reset_a_next = r; attempt_count_next = att_inc; req = 1'b1;
            if (r != 8'd0 && att_inc < cfg.mmc_init) begin
              cmd_code_next = CMD1; command_arg_next = '0; cmd_keep_next = 1'b0;
              cmd_ctx_next = C_CMD1; cs_on_next = 1'b1; frame_index_next = '0;
              phase_next = P_CMD_FRAME; mosi = CMD_START | {2'b00, CMD1};
            end else if (att_inc >= cfg.mmc_init) begin
              cs_on_next = 1'b0; byte_count_next = '0; phase_next = P_INIT_CLOCKS;
              mosi = BYTE_IDLE;
            end else begin
              detected_type_next = TYPE_MMC; phase_next = P_DUMMY; mosi = BYTE_IDLE;
            end
          end
          C_CMD16: begin
            reset_a_next = r;
            if (r != 8'd0 && attempt_count < cfg.blocklen) begin
              attempt_count_next = att_inc; cmd_code_next = CMD16;
              command_arg_next = ARG_BLKLEN; cmd_keep_next = 1'b0; cmd_ctx_next = C_CMD16;
              cs_on_next = 1'b1; frame_index_next = '0; phase_next = P_CMD_FRAME;
              req = 1'b1; mosi = CMD_START | {2'b00, CMD16};
            end else if (r == 8'd0) begin
              clock_fast_next = 1'b1; done = 1'b1; phase_next = P_IDLE;
            end else begin
              cs_on_next = 1'b0; byte_count_next = '0; phase_next = P_INIT_CLOCKS;
              req = 1'b1; mosi = BYTE_IDLE;
            end
          end
          C_CMD17: begin
            if (r != 8'd0) begin
              done = 1'b1; st = r; phase_next = P_IDLE;
            end else begin
              cs_on_next = 1'b1; phase_next = P_RD_TOKEN; req = 1'b1; mosi = BYTE_IDLE;
            end
          end
          default: begin
            if (r != 8'd0) begin
              done = 1'b1; st = r; phase_next = P_IDLE;
            end else begin
              cs_on_next = 1'b1; byte_count_next = '0; phase_next = P_WR_PRE;
              req = 1'b1; mosi = BYTE_IDLE;
            end
          end
        endcase
      end
    end

    res.mosi_byte        = mosi;
    res.exchange_request = req;
    res.chip_select      = cs_on_next;
    res.fast_clock       = clock_fast_next;
    res.need_write_byte  = nwb;
    res.read_valid       = rv;
    res.read_byte        = rb;
    res.done_res         = done;
    res.status           = st;
    res.card_type        = detected_type_next;
  end
endmodule
`default_nettype wire

/* design/sd_card_spi_host_controller_core.sv */
// SD card SPI-mode host controller, top level.
// Output: each result is registered when its beat is accepted.
// Throughput: one beat per cycle unless a held result meets out_stall; the
// output register, a skid-free stage, refills in the same cycle it drains.
// Reset: synchronous active-high rst sets phase idle and loads default limits.
// Depends on sdspi_pkg, sdspi_cfg_regs, sdspi_fsm.
`default_nettype none
module sd_card_spi_host_controller_core import sdspi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  cfg_t      cfg;
  logic      step, has_res;
  out_item_t res;

  // hold input while a result waits and cannot drain
  assign in_stall = out_valid && out_stall;
  assign step = in_valid && !in_stall;

  sdspi_cfg_regs u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );

  sdspi_fsm u_fsm (
    .clk, .rst, .step, .item(in_data), .cfg, .has_res, .res
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= has_res;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_res) out_data <= res;
  end
endmodule
`default_nettype wire
